// File: hdl/wsd_pkg.sv
// wsd_pkg: shared types and constants of the websocket frame deframer.
// Holds the result record, the result kind codes and the frame constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    K_DATA  = 3'd0,
    K_EMPTY = 3'd1,
    K_PONG  = 3'd2,
    K_CLOSE = 3'd3,
    K_ERROR = 3'd4
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        is_text;
    logic [15:0] message_length;
    logic        last;
  } result_t;

  // Parser to top level status
  typedef struct packed {
    logic push;
    logic link_open;
  } parse_stat_t;

  // Frame constants
  localparam logic [3:0] OP_MASK   = 4'hF;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

endpackage

`default_nettype wire

// File: hdl/wsd_parse.sv
// wsd_parse: front end, one received byte per transfer, frame header parsing,
// unmasking and result classification. Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_parse (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  output wsd_pkg::parse_stat_t stat,
  output wsd_pkg::result_t     result
);
  import wsd_pkg::*;

  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_EXT0 = 6'b000100,
    PH_EXT1 = 6'b001000,
    PH_MASK = 6'b010000,
    PH_BODY = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic [7:0]  len_high_r, len_high_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        skip_r, skip_nxt;
  logic        open_r, open_nxt;

  logic        push;
  result_t     res;
  logic        do_after;
  logic        do_start;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic        text;

  assign text = (opcode_r == OP_TEXT);

  // Mask key byte for the current payload position, first key byte first
  always_comb begin
    unique case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign plain = mask_r ? (rx_byte ^ key_byte) : rx_byte;

  // Parse step
  always_comb begin
    phase_nxt    = phase_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    len_high_nxt = len_high_r;
    total_nxt    = total_r;
    left_nxt     = left_r;
    key_nxt      = key_r;
    pos_nxt      = pos_r;
    skip_nxt     = skip_r;
    open_nxt     = open_r;
    push         = 1'b0;
    res          = '0;
    do_after     = 1'b0;
    do_start     = 1'b0;

    if (accept && open_r) begin
      unique case (phase_r)
        PH_HDR1: begin
          mask_nxt = rx_byte[7];
          if (opcode_r == OP_CLOSE) begin
            open_nxt  = 1'b0;
            phase_nxt = PH_HDR0;
            push      = 1'b1;
            res.kind  = K_CLOSE;
          end else if (opcode_r == OP_PING) begin
            push     = 1'b1;
            res.kind = K_PONG;
            if (rx_byte[6:0] == LEN_EXT64) begin
              phase_nxt = PH_HDR0;
            end else begin
              skip_nxt = 1'b1;
              if (rx_byte[6:0] == LEN_EXT16) begin
                phase_nxt = PH_EXT0;
              end else begin
                total_nxt = {9'd0, rx_byte[6:0]};
                do_after  = 1'b1;
              end
            end
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            phase_nxt = PH_HDR0;
            push      = 1'b1;
            res.kind  = K_ERROR;
          end else if (rx_byte[6:0] == LEN_EXT16) begin
            phase_nxt = PH_EXT0;
          end else begin
            total_nxt = {9'd0, rx_byte[6:0]};
            do_after  = 1'b1;
          end
        end
        PH_EXT0: begin
          len_high_nxt = rx_byte;
          phase_nxt    = PH_EXT1;
        end
        PH_EXT1: begin
          total_nxt = {len_high_r, rx_byte};
          do_after  = 1'b1;
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          if (pos_r == 2'd3) begin
            pos_nxt  = 2'd0;
            do_start = 1'b1;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end
        PH_BODY: begin
          pos_nxt  = pos_r + 2'd1;
          left_nxt = left_r - 16'd1;
          if (left_nxt == 16'd0) begin
            phase_nxt = PH_HDR0;
          end
          if (skip_r) begin
            if (left_nxt == 16'd0) begin
              skip_nxt = 1'b0;
            end
          end else begin
            push               = 1'b1;
            res.kind           = K_DATA;
            res.payload_byte   = plain;
            res.is_text        = text;
            res.message_length = total_r;
            res.last           = (left_nxt == 16'd0);
          end
        end
        default: begin
          opcode_nxt = rx_byte[3:0] & OP_MASK;
          skip_nxt   = 1'b0;
          phase_nxt  = PH_HDR1;
        end
      endcase

      // Length known: read the mask key or start the body
      if (do_after) begin
        if (mask_nxt) begin
          pos_nxt   = 2'd0;
          phase_nxt = PH_MASK;
        end else begin
          do_start = 1'b1;
        end
      end

      // Header complete: empty frame or payload
      if (do_start) begin
        if (total_nxt == 16'd0) begin
          phase_nxt = PH_HDR0;
          if (skip_nxt) begin
            skip_nxt = 1'b0;
          end else begin
            push        = 1'b1;
            res.kind    = K_EMPTY;
            res.is_text = text;
            res.last    = 1'b1;
          end
        end else begin
          left_nxt  = total_nxt;
          pos_nxt   = 2'd0;
          phase_nxt = PH_BODY;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      opcode_r   <= 4'd0;
      mask_r     <= 1'b0;
      len_high_r <= 8'd0;
      total_r    <= 16'd0;
      left_r     <= 16'd0;
      key_r      <= 32'd0;
      pos_r      <= 2'd0;
      skip_r     <= 1'b0;
      open_r     <= 1'b1;
    end else begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      mask_r     <= mask_nxt;
      len_high_r <= len_high_nxt;
      total_r    <= total_nxt;
      left_r     <= left_nxt;
      key_r      <= key_nxt;
      pos_r      <= pos_nxt;
      skip_r     <= skip_nxt;
      open_r     <= open_nxt;
    end
  end

  assign stat.push      = push;
  assign stat.link_open = open_r;
  assign result         = res;

endmodule

`default_nettype wire

// File: hdl/wsd_queue.sv
// wsd_queue: short result queue between the parser and the output channel.
// Its head drives the result channel directly. Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wsd_pkg::result_t      push_data,
  input  wire logic             pop,
  output wsd_pkg::result_t      head,
  output logic                  not_empty,
  output logic                  full,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import wsd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  result_t         slot_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage slots, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  assign head      = slot_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == DEPTH_CNT);
  assign count     = cnt_r;

endmodule

`default_nettype wire

// File: hdl/websocket_frame_deframer.sv
// websocket_frame_deframer: top level of the websocket receive-side deframer.
// Joins the parser front end (wsd_parse) and the result queue (wsd_queue).
//
// Usage:
//   Input channel in_valid / in_stall / in_rx_byte carries one received byte
//   of the stream per transfer. Result channel out_valid / out_stall carries
//   out_kind, out_payload_byte, out_is_text, out_message_length, out_last.
//   Header bytes, the extended length, the mask key and ping payloads give no
//   result; payload bytes, empty messages, pong requests, close and error do.
//   A result is written into the queue at the transfer of the byte that
//   causes it and reaches the output once the results ahead of it are taken.
//   Throughput: one byte per cycle while in_stall is low; the parse step is
//   combinational; a QUEUE_DEPTH-entry queue parts parser and output side.
//   When the receiver stalls, results collect in the queue; once it holds
//   QUEUE_DEPTH results, in_stall rises until a result is taken.
//   After a close frame all further bytes are taken and dropped until reset.
//   Reset (rst_n low, synchronous) empties the queue and returns the parser
//   to the first header byte with the link open.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_is_text,
  output logic [15:0]      out_message_length,
  output logic             out_last
);
  import wsd_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          in_xfer;
  logic          out_xfer;
  parse_stat_t   stat;
  result_t       parse_res;
  result_t       head;
  logic          q_not_empty;
  logic          q_full;
  logic [CW-1:0] q_count;

  assign in_stall = q_full;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Front end: parse and classify
  wsd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .rx_byte (in_rx_byte),
    .stat    (stat),
    .result  (parse_res)
  );

  // Back end: result queue feeding the output channel
  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stat.push),
    .push_data (parse_res),
    .pop       (out_xfer),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count     (q_count)
  );

  assign out_valid          = q_not_empty;
  assign out_kind           = head.kind;
  assign out_payload_byte   = head.payload_byte;
  assign out_is_text        = head.is_text;
  assign out_message_length = head.message_length;
  assign out_last           = head.last;

  // Assertions
  a_push_only_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    stat.push |-> in_xfer)
    else $error("result pushed without an input transfer");

  a_no_result_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.link_open |-> !stat.push)
    else $error("result produced after close");

  a_close_shuts_link: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.push && parse_res.kind == K_CLOSE) |=> !stat.link_open)
    else $error("close result did not shut the link");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.push && !out_xfer) |=> (q_count == $past(q_count) + CW'(1)))
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// File: tb/wsd_frame_checker.sv
// wsd_frame_checker: watches both channels of the websocket deframer, predicts the
// result of every accepted byte and compares each delivered result in order.
// Depends on wsd_pkg for the result kinds, the result record and the frame constants.
`timescale 1ns / 1ps

module wsd_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_is_text,
  input  logic [15:0] out_message_length,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output logic        at_header
);

  import wsd_pkg::*;

  typedef enum logic [2:0] {
    P_FIRST,
    P_LEN7,
    P_EXT_HI,
    P_EXT_LO,
    P_KEY,
    P_DATA
  } parse_phase_t;

  // Predicted parser state
  parse_phase_t ph;
  logic [3:0]   opcode;
  logic         masked;
  logic [7:0]   len_hi;
  logic [15:0]  frame_len;
  logic [15:0]  left;
  logic [31:0]  key;
  logic [1:0]   key_idx;
  logic         in_ping;
  logic         link_up;

  // Deframed results waiting for their transfer, oldest first
  result_t deframed_q[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    at_header       = 1'b1;
  end

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] seen_v);
    if (want_v !== seen_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, seen_v);
    end
  endtask

  // Header done: start the payload, or finish an empty frame
  task automatic open_payload(output bit got, output result_t r);
    got = 1'b0;
    r   = '0;
    if (frame_len == 16'd0) begin
      ph = P_FIRST;
      if (in_ping) begin
        in_ping = 1'b0;
      end else begin
        got       = 1'b1;
        r.kind    = K_EMPTY;
        r.is_text = (opcode == OP_TEXT);
        r.last    = 1'b1;
      end
    end else begin
      left    = frame_len;
      key_idx = 2'd0;
      ph      = P_DATA;
    end
  endtask

  // Length known: collect the mask key first when there is one
  task automatic finish_header(output bit got, output result_t r);
    got = 1'b0;
    r   = '0;
    if (masked) begin
      key_idx = 2'd0;
      ph      = P_KEY;
    end else begin
      open_payload(got, r);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit got, output result_t r);
    logic [6:0] len7;
    logic [7:0] v;
    bit         done;
    bit         unused_got;
    result_t    unused_r;
    got  = 1'b0;
    r    = '0;
    len7 = b[6:0];
    if (link_up) begin
      case (ph)
        P_LEN7: begin
          masked = b[7];
          if (opcode == OP_CLOSE) begin
            link_up = 1'b0;
            ph      = P_FIRST;
            got     = 1'b1;
            r.kind  = K_CLOSE;
          end else if (opcode == OP_PING) begin
            // pong request now, the rest of the ping is swallowed
            if (len7 == LEN_EXT64) begin
              ph = P_FIRST;
            end else begin
              in_ping = 1'b1;
              if (len7 == LEN_EXT16) begin
                ph = P_EXT_HI;
              end else begin
                frame_len = {9'd0, len7};
                finish_header(unused_got, unused_r);
              end
            end
            got    = 1'b1;
            r.kind = K_PONG;
          end else if (len7 == LEN_EXT64) begin
            ph     = P_FIRST;
            got    = 1'b1;
            r.kind = K_ERROR;
          end else if (len7 == LEN_EXT16) begin
            ph = P_EXT_HI;
          end else begin
            frame_len = {9'd0, len7};
            finish_header(got, r);
          end
        end
        P_EXT_HI: begin
          len_hi = b;
          ph     = P_EXT_LO;
        end
        P_EXT_LO: begin
          frame_len = {len_hi, b};
          finish_header(got, r);
        end
        P_KEY: begin
          key = {key[23:0], b};
          if (key_idx == 2'd3) begin
            key_idx = 2'd0;
            open_payload(got, r);
          end else begin
            key_idx = key_idx + 2'd1;
          end
        end
        P_DATA: begin
          // key byte 0 unmasks payload byte 0, cycling every four
          v = b;
          if (masked) v = v ^ key[8 * (3 - key_idx) +: 8];
          key_idx = key_idx + 2'd1;
          left    = left - 16'd1;
          done    = (left == 16'd0);
          if (done) ph = P_FIRST;
          if (in_ping) begin
            if (done) in_ping = 1'b0;
          end else begin
            got              = 1'b1;
            r.kind           = K_DATA;
            r.payload_byte   = v;
            r.is_text        = (opcode == OP_TEXT);
            r.message_length = frame_len;
            r.last           = done;
          end
        end
        default: begin
          opcode  = b[3:0];
          in_ping = 1'b0;
          ph      = P_LEN7;
        end
      endcase
    end
  endtask

  // Compare delivered results, then predict from the accepted byte
  always @(posedge clk) begin : monitor
    result_t want;
    result_t pred;
    bit      got;
    if (!rst_n) begin
      ph        = P_FIRST;
      opcode    = 4'd0;
      masked    = 1'b0;
      len_hi    = 8'd0;
      frame_len = 16'd0;
      left      = 16'd0;
      key       = 32'd0;
      key_idx   = 2'd0;
      in_ping   = 1'b0;
      link_up   = 1'b1;
      deframed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual kind %0d byte %0h",
                   $time, out_kind, out_payload_byte);
        end else begin
          want = deframed_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
          check_field("is_text", 16'(want.is_text), 16'(out_is_text));
          check_field("message_length", want.message_length, out_message_length);
          check_field("last", 16'(want.last), 16'(out_last));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte, got, pred);
        if (got) deframed_q.push_back(pred);
      end
    end
    pending   = deframed_q.size();
    at_header = link_up && (ph == P_FIRST);
  end

endmodule

// File: tb/tb_websocket_frame_deframer.sv
// tb_websocket_frame_deframer: drives byte streams of websocket frames into the
// deframer with random idling on both sides and reports the verdict.
// Depends on wsd_pkg, websocket_frame_deframer and wsd_frame_checker.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;

  import wsd_pkg::*;

  localparam logic [3:0] OP_BINARY      = 4'h2;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_BYTES   = 240;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic        out_is_text;
  logic [15:0] out_message_length;
  logic        out_last;

  int   fail_count;
  int   pending;
  int   results_checked;
  logic at_header;

  bit   idle_en;
  bit   paused;
  int   bytes_sent;
  int   frames_sent;
  int   noise_bursts;
  int   quiet_cycles;
  int   mark;

  websocket_frame_deframer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_is_text        (out_is_text),
    .out_message_length (out_message_length),
    .out_last           (out_last)
  );

  wsd_frame_checker deframe_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_is_text        (out_is_text),
    .out_message_length (out_message_length),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_checked    (results_checked),
    .at_header          (at_header)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stalls in bursts
  initial out_stall = 1'b0;
  always begin
    @(negedge clk);
    if (idle_en && rst_n && $urandom_range(0, 9) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      out_stall = 1'b0;
    end
  end

  // Watchdog on cycles without any transfer
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transfer for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // One byte transfer; returns at the following falling edge with valid still high
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has been delivered
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Well-formed frame with random flags, key and payload
  task automatic send_frame(input logic [3:0] op, input bit masked, input int len,
                            input bit ext16, input bit len64);
    logic [3:0] flags;
    int         i;
    flags = 4'($urandom_range(0, 15));
    send_byte({flags, op});
    if (len64) begin
      send_byte({masked, LEN_EXT64});
    end else begin
      if (ext16 || len > 125) begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end else begin
        send_byte({masked, len[6:0]});
      end
      if (masked) repeat (4) send_byte(8'($urandom_range(0, 255)));
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
    end
    frames_sent++;
  endtask

  // Mostly data frames; some pings, 64-bit lengths and raw noise
  task automatic send_random_frame();
    int         pick;
    int         len;
    logic [3:0] op;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // noise never carries a close opcode and keeps lengths short (bit 6 clear),
      // so realigning on zero bytes afterwards stays brief
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b[3:0] == OP_CLOSE) b[0] = 1'b1;
        b[6] = 1'b0;
        send_byte(b);
      end
      while (!at_header) send_byte(8'h00);
      noise_bursts++;
    end else if (pick < 18) begin
      op = $urandom_range(0, 1) ? OP_PING : OP_BINARY;
      send_frame(op, 1'($urandom_range(0, 1)), 0, 1'b0, 1'b1);
    end else if (pick < 30) begin
      send_frame(OP_PING, 1'($urandom_range(0, 1)), $urandom_range(0, 6),
                 $urandom_range(0, 3) == 0, 1'b0);
    end else begin
      if ($urandom_range(0, 1)) begin
        op = OP_TEXT;
      end else begin
        do op = 4'($urandom_range(0, 15)); while (op == OP_CLOSE || op == OP_PING);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)     len = 0;
      else if (pick < 8) len = $urandom_range(1, 12);
      else               len = $urandom_range(120, 160);
      send_frame(op, 1'($urandom_range(0, 1)), len, $urandom_range(0, 5) == 0, 1'b0);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = 8'h00;
    idle_en      = 1'b1;
    paused       = 1'b0;
    bytes_sent   = 0;
    frames_sent  = 0;
    noise_bursts = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // text frame carrying both byte extremes
    send_byte({4'h8, OP_TEXT});
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    // empty messages, plain and masked
    send_frame(OP_TEXT, 1'b0, 0, 1'b0, 1'b0);
    send_frame(OP_BINARY, 1'b1, 0, 1'b0, 1'b0);
    // pings empty and with extended length, then 64-bit lengths on binary and ping
    send_frame(OP_PING, 1'b0, 0, 1'b0, 1'b0);
    send_frame(OP_PING, 1'b0, 3, 1'b1, 1'b0);
    send_frame(OP_BINARY, 1'b0, 0, 1'b0, 1'b1);
    send_frame(OP_PING, 1'b0, 0, 1'b0, 1'b1);

    // one masked frame just past the 7-bit length range
    send_frame(OP_BINARY, 1'b1, 130, 1'b1, 1'b0);

    mark = bytes_sent;
    while (bytes_sent - mark < RANDOM_BYTES) begin
      if (!paused && bytes_sent - mark >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      if (bytes_sent - mark >= RANDOM_BYTES - 70) idle_en = 1'b0;
      send_random_frame();
    end

    // close, then bytes that must be dropped
    wait_drained();
    send_frame(OP_CLOSE, 1'b1, 0, 1'b0, 1'b0);
    send_frame(OP_TEXT, 1'b0, 2, 1'b0, 1'b0);

    wait_drained();
    repeat (16) @(negedge clk);

    $display("Sent %0d bytes in %0d frames plus %0d noise bursts: text, binary, empty,",
             bytes_sent, frames_sent, noise_bursts);
    $display("masked, extended, ping, 64-bit length and close; %0d results compared",
             results_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
